// File: rtl/bcomp_pkg.sv
// ----------------------------------------------------------------------------
// bcomp_pkg
// Shared types and constants for the barometric compensation block.
// ----------------------------------------------------------------------------
package bcomp_pkg;

	localparam int unsigned DataWidth = 32;
	localparam int unsigned CfgWidth  = 48;
	localparam int unsigned CntWidth  = $clog2(DataWidth);

	localparam logic [1:0] CfgFirstThree    = 2'd0;
	localparam logic [1:0] CfgUnsignedThree = 2'd1;
	localparam logic [1:0] CfgBPair         = 2'd2;
	localparam logic [1:0] CfgMPair         = 2'd3;

	localparam logic [0:0] OpTemp  = 1'b0;
	localparam logic [0:0] OpPress = 1'b1;

	localparam logic [31:0] TempOffset  = 32'd4000;
	localparam logic [31:0] PressHalf   = 32'd32768;
	localparam logic [31:0] PressScale  = 32'd50000;
	localparam logic [31:0] PressC1     = 32'd3038;
	localparam logic [31:0] PressC2     = 32'hFFFF_E343;
	localparam logic [31:0] PressC3     = 32'd3791;

	typedef struct packed {
		logic        opcode;
		logic [23:0] raw_reading;
		logic [1:0]  oversampling;
	} in_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] compensated_value;
		logic               divide_error;
	} out_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} unit_req_t;

endpackage

// File: rtl/barometric_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_compensation_top
// Integer temperature and pressure compensation with serial arithmetic.
// ----------------------------------------------------------------------------
// One transaction at a time; in_stall stays high from the accepting edge until
// the result is loaded into the output register. Every serial multiply or
// divide is issued through a registered start, iterates over the 32 operand
// bits and then reports done. A temperature reading takes one multiply and one
// divide and a pressure reading ten multiplies and one divide; the result then
// passes through ST_OUT into the output register, which raises out_valid.
// A held result stalls that load. A zero divisor ends the transaction early
// with value 0 and divide_error set: after the first multiply for temperature,
// after the seventh multiply for pressure.
module barometric_compensation_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bcomp_pkg::in_t    in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bcomp_pkg::out_t   out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [47:0]       cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		STEP_T0, STEP_TD, STEP_P0, STEP_P1, STEP_P2, STEP_P3, STEP_P4,
		STEP_P5, STEP_P6, STEP_PD, STEP_P7, STEP_P8, STEP_P9
	} step_t;

	state_t      state_q;
	step_t       step_q;
	logic [47:0] cal0_q, cal1_q;
	logic [31:0] cal2_q, cal3_q;
	logic [31:0] tt_q;
	logic        op_q;
	logic [1:0]  oss_q;
	logic [31:0] up_q, b6_q, sq_q, x1_q, b3_q, b4_q, p_q, y1_q;
	logic        neg_q, b7hi_q;
	logic [31:0] res_q;
	logic        err_q;
	logic        out_valid_q;
	bcomp_pkg::out_t out_q;
	bcomp_pkg::unit_req_t mul_req_q, div_req_q;
	logic        mul_done, div_done;
	logic [31:0] prod, quo;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] sr11, sr12, sr13, sr15, sr16;
	logic [31:0] tden, tden_abs, tnum, tnum_abs, tq, tt_new;
	logic [31:0] x3_a, b3_t, x3_b, p_new, p_sr8;
	logic        accept, out_free;
	logic        mul_start, div_start, out_load;

	assign ac1 = {{16{cal0_q[47]}}, cal0_q[47:32]};
	assign ac2 = {{16{cal0_q[31]}}, cal0_q[31:16]};
	assign ac3 = {{16{cal0_q[15]}}, cal0_q[15:0]};
	assign ac4 = {16'd0, cal1_q[47:32]};
	assign ac5 = {16'd0, cal1_q[31:16]};
	assign ac6 = {16'd0, cal1_q[15:0]};
	assign b1  = {{16{cal2_q[31]}}, cal2_q[31:16]};
	assign b2  = {{16{cal2_q[15]}}, cal2_q[15:0]};
	assign mc  = {{16{cal3_q[31]}}, cal3_q[31:16]};
	assign md  = {{16{cal3_q[15]}}, cal3_q[15:0]};

	assign sr11 = 32'($signed(prod) >>> 11);
	assign sr12 = 32'($signed(prod) >>> 12);
	assign sr13 = 32'($signed(prod) >>> 13);
	assign sr15 = 32'($signed(prod) >>> 15);
	assign sr16 = 32'($signed(prod) >>> 16);

	assign tden     = sr15 + md;
	assign tden_abs = tden[31] ? 32'(-tden) : tden;
	assign tnum     = {mc[20:0], 11'd0};
	assign tnum_abs = tnum[31] ? 32'(-tnum) : tnum;
	assign tq       = neg_q ? 32'(-quo) : quo;
	assign tt_new   = x1_q + tq;

	assign x3_a  = x1_q + sr11;
	assign b3_t  = ({ac1[29:0], 2'b00} + x3_a) << oss_q;
	assign x3_b  = 32'($signed(x1_q + sr16 + 32'd2) >>> 2);
	assign p_new = b7hi_q ? {quo[30:0], 1'b0} : quo;
	assign p_sr8 = 32'($signed(p_new) >>> 8);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_OUT) && out_free;

	assign mul_start = accept
		|| (state_q == ST_MUL && mul_done && step_q != STEP_T0
			&& step_q != STEP_P6 && step_q != STEP_P9)
		|| (state_q == ST_DIV && div_done && step_q != STEP_TD);
	assign div_start = (state_q == ST_MUL) && mul_done
		&& ((step_q == STEP_T0 && tden != '0) || (step_q == STEP_P6 && b4_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal0_q <= '0;
			cal1_q <= '0;
			cal2_q <= '0;
			cal3_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcomp_pkg::CfgFirstThree:    cal0_q <= cfg_data;
				bcomp_pkg::CfgUnsignedThree: cal1_q <= cfg_data;
				bcomp_pkg::CfgBPair:         cal2_q <= cfg_data[31:0];
				bcomp_pkg::CfgMPair:         cal3_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_T0;
			tt_q        <= '0;
			out_valid_q <= 1'b0;
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			mul_req_q.start <= mul_start;
			div_req_q.start <= div_start;
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= in_data.opcode;
						oss_q <= in_data.oversampling;
						up_q  <= 32'(in_data.raw_reading
							>> (4'd8 - {2'd0, in_data.oversampling}));
						state_q <= ST_MUL;
						if (in_data.opcode == bcomp_pkg::OpTemp) begin
							step_q <= STEP_T0;
							mul_req_q.a <= {16'd0, in_data.raw_reading[15:0]} - ac6;
							mul_req_q.b <= ac5;
						end else begin
							step_q <= STEP_P0;
							b6_q <= tt_q - bcomp_pkg::TempOffset;
							mul_req_q.a <= tt_q - bcomp_pkg::TempOffset;
							mul_req_q.b <= tt_q - bcomp_pkg::TempOffset;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						unique case (step_q)
							STEP_T0: begin
								x1_q <= sr15;
								if (tden == '0) begin
									res_q <= '0;
									err_q <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									neg_q <= tnum[31] ^ tden[31];
									div_req_q.a <= tnum_abs;
									div_req_q.b <= tden_abs;
									step_q <= STEP_TD;
									state_q <= ST_DIV;
								end
							end
							STEP_P0: begin
								sq_q <= sr12;
								mul_req_q.a <= b2;
								mul_req_q.b <= sr12;
								step_q <= STEP_P1;
							end
							STEP_P1: begin
								x1_q <= sr11;
								mul_req_q.a <= ac2;
								mul_req_q.b <= b6_q;
								step_q <= STEP_P2;
							end
							STEP_P2: begin
								b3_q <= 32'($signed(b3_t + 32'd2) >>> 2);
								mul_req_q.a <= ac3;
								mul_req_q.b <= b6_q;
								step_q <= STEP_P3;
							end
							STEP_P3: begin
								x1_q <= sr13;
								mul_req_q.a <= b1;
								mul_req_q.b <= sq_q;
								step_q <= STEP_P4;
							end
							STEP_P4: begin
								mul_req_q.a <= ac4;
								mul_req_q.b <= x3_b + bcomp_pkg::PressHalf;
								step_q <= STEP_P5;
							end
							STEP_P5: begin
								b4_q <= prod >> 15;
								mul_req_q.a <= up_q - b3_q;
								mul_req_q.b <= bcomp_pkg::PressScale >> oss_q;
								step_q <= STEP_P6;
							end
							STEP_P6: begin
								if (b4_q == '0) begin
									res_q <= '0;
									err_q <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									b7hi_q <= prod[31];
									div_req_q.a <= prod[31] ? prod
										: {prod[30:0], 1'b0};
									div_req_q.b <= b4_q;
									step_q <= STEP_PD;
									state_q <= ST_DIV;
								end
							end
							STEP_P7: begin
								mul_req_q.a <= prod;
								mul_req_q.b <= bcomp_pkg::PressC1;
								step_q <= STEP_P8;
							end
							STEP_P8: begin
								y1_q <= sr16;
								mul_req_q.a <= p_q;
								mul_req_q.b <= bcomp_pkg::PressC2;
								step_q <= STEP_P9;
							end
							default: begin
								res_q <= p_q + 32'($signed(y1_q + sr16
									+ bcomp_pkg::PressC3) >>> 4);
								err_q <= 1'b0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (step_q == STEP_TD) begin
							tt_q  <= tt_new;
							res_q <= 32'($signed(tt_new + 32'd8) >>> 4);
							err_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							p_q <= p_new;
							mul_req_q.a <= p_sr8;
							mul_req_q.b <= p_sr8;
							step_q <= STEP_P7;
							state_q <= ST_MUL;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_q.result_kind <= op_q;
						out_q.compensated_value <= res_q;
						out_q.divide_error <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	bcomp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.done   (mul_done),
		.prod   (prod)
	);

	bcomp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("accepted transaction did not stall input");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req_q.start && div_req_q.start))
		else $error("multiplier and divider started together");

	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result shown outside output state");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.divide_error) |-> (out_q.compensated_value == '0))
		else $error("divide error with nonzero value");

endmodule

// File: rtl/bcomp_mul.sv
// ----------------------------------------------------------------------------
// bcomp_mul
// Bit-serial shift-add multiplier, low 32 bits of the product.
// ----------------------------------------------------------------------------
module bcomp_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcomp_pkg::unit_req_t req,
	output logic                 done,
	output logic [31:0]          prod
);

	logic [31:0]                  a_q;
	logic [31:0]                  b_q;
	logic [31:0]                  acc_q;
	logic [bcomp_pkg::CntWidth-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[30:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: rtl/bcomp_div.sv
// ----------------------------------------------------------------------------
// bcomp_div
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcomp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcomp_pkg::unit_req_t req,
	output logic                 done,
	output logic [31:0]          quo
);

	logic [31:0]                  rem_q;
	logic [31:0]                  quo_q;
	logic [31:0]                  den_q;
	logic [bcomp_pkg::CntWidth-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [32:0]                  part;
	logic [32:0]                  trial;

	assign part  = {rem_q, quo_q[31]};
	assign trial = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.a;
			den_q <= req.b;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
			end else begin
				rem_q <= part[31:0];
			end
			quo_q <= {quo_q[30:0], ~trial[32]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: tb/sv/tb_barometric_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_barometric_compensation_top
// Self-checking bench for the barometric compensation block: a directed table
// of readings and calibration sets, then random bursts of readings under
// several calibration sets, checked against an in-bench predictor or known values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_barometric_compensation_top;

	localparam int MaxCycles = 3_000_000;
	localparam int RandItems = 1900;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	bcomp_pkg::in_t   in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	bcomp_pkg::out_t  out_data;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [47:0]      cfg_data = '0;

	barometric_compensation_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [47:0]     coef_ac123, coef_ac456;
	logic [31:0]     coef_b12, coef_m12;
	logic [31:0]     stored_b5;
	bcomp_pkg::out_t pending_results[$];
	int              mismatch_count = 0;
	int              cycle_count = 0;
	bit              stall_pattern_on = 1'b1;

	typedef struct {
		bcomp_pkg::in_t  reading;
		bit              has_known;
		bcomp_pkg::out_t known;
	} table_row_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic bcomp_pkg::out_t compensate(input bcomp_pkg::in_t r);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, p, y1, y2, up;
		logic signed [31:0] q;
		bcomp_pkg::out_t o;
		ac1 = sx16(coef_ac123[47:32]); ac2 = sx16(coef_ac123[31:16]);
		ac3 = sx16(coef_ac123[15:0]);
		ac4 = {16'd0, coef_ac456[47:32]}; ac5 = {16'd0, coef_ac456[31:16]};
		ac6 = {16'd0, coef_ac456[15:0]};
		b1 = sx16(coef_b12[31:16]); b2 = sx16(coef_b12[15:0]);
		mc = sx16(coef_m12[31:16]); md = sx16(coef_m12[15:0]);
		o = '0;
		if (r.opcode == bcomp_pkg::OpTemp) begin
			o.result_kind = bcomp_pkg::OpTemp;
			x1 = asr(({16'd0, r.raw_reading[15:0]} - ac6) * ac5, 15);
			den = x1 + md;
			if (den == 0) begin
				o.divide_error = 1'b1;
				return o;
			end
			q = $signed(mc * 32'd2048) / $signed(den);
			stored_b5 = x1 + q;
			o.compensated_value = asr(stored_b5 + 32'd8, 4);
		end else begin
			o.result_kind = bcomp_pkg::OpPress;
			up = {8'd0, r.raw_reading} >> (8 - r.oversampling);
			b6 = stored_b5 - bcomp_pkg::TempOffset;
			sq = asr(b6 * b6, 12);
			x1 = asr(b2 * sq, 11);
			x2 = asr(ac2 * b6, 11);
			x3 = x1 + x2;
			b3 = asr(((ac1 * 32'd4 + x3) << r.oversampling) + 32'd2, 2);
			x1 = asr(ac3 * b6, 13);
			x2 = asr(b1 * sq, 16);
			x3 = asr(x1 + x2 + 32'd2, 2);
			b4 = (ac4 * (x3 + bcomp_pkg::PressHalf)) >> 15;
			b7 = (up - b3) * (bcomp_pkg::PressScale >> r.oversampling);
			if (b4 == 0) begin
				o.divide_error = 1'b1;
				return o;
			end
			if (!b7[31]) p = (b7 << 1) / b4;
			else p = (b7 / b4) << 1;
			y1 = asr(p, 8) * asr(p, 8);
			y1 = asr(y1 * bcomp_pkg::PressC1, 16);
			y2 = asr(p * bcomp_pkg::PressC2, 16);
			o.compensated_value = p + asr(y1 + y2 + bcomp_pkg::PressC3, 4);
		end
		return o;
	endfunction

	task automatic write_cal(input logic [1:0] idx, input logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			bcomp_pkg::CfgFirstThree:    coef_ac123 = val;
			bcomp_pkg::CfgUnsignedThree: coef_ac456 = val;
			bcomp_pkg::CfgBPair:         coef_b12 = val[31:0];
			default:                     coef_m12 = val[31:0];
		endcase
	endtask

	task automatic load_cal(input logic [47:0] a, input logic [47:0] u,
			input logic [31:0] b, input logic [31:0] m);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (450) @(negedge clk);
		write_cal(bcomp_pkg::CfgFirstThree, a);
		write_cal(bcomp_pkg::CfgUnsignedThree, u);
		write_cal(bcomp_pkg::CfgBPair, {16'd0, b});
		write_cal(bcomp_pkg::CfgMPair, {16'd0, m});
		cfg_we <= 1'b0;
	endtask

	// drive one transaction; the known value, when given, overrides prediction
	task automatic send_reading(input bcomp_pkg::in_t r, input bit has_known,
			input bcomp_pkg::out_t known);
		bcomp_pkg::out_t pred;
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = compensate(r);
		pending_results.push_back(has_known ? known : pred);
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_burst(input int n, input int press_pct);
		bcomp_pkg::in_t r;
		int gap;
		for (int i = 0; i < n; i++) begin
			r.opcode = ($urandom_range(99) < press_pct) ? bcomp_pkg::OpPress
				: bcomp_pkg::OpTemp;
			r.raw_reading = 24'($urandom());
			r.oversampling = 2'($urandom());
			gap = ($urandom_range(3) == 0) ? $urandom_range(20) : 0;
			repeat (gap) @(negedge clk);
			send_reading(r, 1'b0, '0);
		end
	endtask

	function automatic table_row_t row(input logic op, input logic [23:0] raw,
			input logic [1:0] oss, input bit hk, input logic ek, input int ev,
			input logic ee);
		table_row_t t;
		t.reading = '{opcode: op, raw_reading: raw, oversampling: oss};
		t.has_known = hk;
		t.known = '{result_kind: ek, compensated_value: ev, divide_error: ee};
		return t;
	endfunction

	always @(negedge clk) begin
		if ($urandom_range(255) == 0) stall_pattern_on <= ~stall_pattern_on;
		out_stall <= stall_pattern_on ? ($urandom_range(3) == 0) : 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (out_valid && !out_stall && arst_n) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transaction: %p", out_data);
			end else begin
				bcomp_pkg::out_t e;
				e = pending_results.pop_front();
				if (out_data.result_kind !== e.result_kind
						|| out_data.compensated_value !== e.compensated_value
						|| out_data.divide_error !== e.divide_error) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, got %p", e, out_data);
				end
			end
		end
		if (cycle_count >= MaxCycles) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	table_row_t directed[$];

	initial begin
		int sent;
		coef_ac123 = '0; coef_ac456 = '0; coef_b12 = '0; coef_m12 = '0;
		stored_b5 = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all coefficients zero: every divisor is zero
		directed.push_back(row(bcomp_pkg::OpTemp, 24'h00_6C_FA, 0, 1,
			bcomp_pkg::OpTemp, 0, 1));
		directed.push_back(row(bcomp_pkg::OpPress, 24'hFF_FFFF, 3, 1,
			bcomp_pkg::OpPress, 0, 1));
		directed.push_back(row(bcomp_pkg::OpPress, 24'h00_0000, 0, 1,
			bcomp_pkg::OpPress, 0, 1));
		foreach (directed[i])
			send_reading(directed[i].reading, directed[i].has_known, directed[i].known);
		directed.delete();

		// datasheet-like calibration
		load_cal({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
		directed.push_back(row(bcomp_pkg::OpPress, 24'h5D23_00, 0, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpTemp, 24'h00_6CFA, 0, 0, 0, 0, 0));
		for (int o = 0; o < 4; o++)
			directed.push_back(row(bcomp_pkg::OpPress, 24'h5D23_00, 2'(o), 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpTemp, 24'hFF_0000, 3, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpTemp, 24'h00_FFFF, 0, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpPress, 24'hFF_FFFF, 3, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpPress, 24'h00_0000, 3, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpPress, 24'hAA_AAAA, 1, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpPress, 24'h55_5555, 2, 0, 0, 0, 0));
		foreach (directed[i])
			send_reading(directed[i].reading, directed[i].has_known, directed[i].known);
		directed.delete();

		// extreme coefficients, wrapping everywhere
		load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h7FFF_8000, 32'h8000_7FFF);
		directed.push_back(row(bcomp_pkg::OpTemp, 24'h00_0000, 0, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpPress, 24'hFF_FFFF, 0, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpTemp, 24'h00_FFFF, 0, 0, 0, 0, 0));
		directed.push_back(row(bcomp_pkg::OpPress, 24'h80_0000, 3, 0, 0, 0, 0));
		foreach (directed[i])
			send_reading(directed[i].reading, directed[i].has_known, directed[i].known);
		directed.delete();

		// X1 = 0 with MD = 0: zero temperature divisor, B5 kept
		load_cal({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'd0, 16'd0},
			{16'h8000, 16'h7FFF}, {16'h7FFF, 16'd0});
		directed.push_back(row(bcomp_pkg::OpTemp, 24'h00_1234, 0, 1,
			bcomp_pkg::OpTemp, 0, 1));
		directed.push_back(row(bcomp_pkg::OpPress, 24'h12_3456, 2, 0, 0, 0, 0));
		foreach (directed[i])
			send_reading(directed[i].reading, directed[i].has_known, directed[i].known);
		directed.delete();

		sent = 0;
		for (int phase = 0; sent < RandItems; phase++) begin
			case (phase % 4)
				0: load_cal({16'd408 + 16'($urandom_range(200)), -16'sd72, -16'sd14383},
					{16'd32741, 16'd32757 - 16'($urandom_range(3000)), 16'd23153},
					{16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
				1: load_cal(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
					$urandom(), $urandom());
				2: load_cal(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
					$urandom(), {$urandom_range(1) ? 16'h8000 : 16'h7FFF,
					16'($urandom_range(3))});
				default: load_cal(48'hFFFF_0000_7FFF, {16'd1, $urandom()},
					32'h0000_FFFF, 32'h8000_8000);
			endcase
			for (int b = 0; b < 4 && sent < RandItems; b++) begin
				int n;
				n = $urandom_range(4, 40);
				send_burst(n, $urandom_range(30, 80));
				sent += n;
				repeat ($urandom_range(60)) @(negedge clk);
			end
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
